FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define RAD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true outside reset
`define RAD_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

FILE: rtl/rad_pkg.sv
// ----------------------------------------------------------------------------
// rad_pkg
// Types and constants of the deadlock-detecting resource allocator.
// ----------------------------------------------------------------------------
package rad_pkg;

	localparam int NUM_PROCESSES_DEF = 16;
	localparam int NUM_RESOURCES_DEF = 16;

	localparam int CFG_W    = 5;
	localparam int PIDX_W   = 4;
	localparam int RIDX_W   = 4;
	localparam int STATUS_W = 3;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [CFG_W-1:0] RESOURCES_RESET = 5'd5;

	// register word index (paddr[2])
	localparam logic [0:0] REG_RESOURCES_IN_USE = 1'b0;

	localparam logic ACT_REQUEST = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_WAIT      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DEADLOCK  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd4;

	typedef struct packed {
		logic              action;
		logic [PIDX_W-1:0] process_index;
		logic [RIDX_W-1:0] resource_index;
	} in_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PIDX_W-1:0]   victim_process;
	} out_rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic start;
		logic step;
		logic finish;
	} rad_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic go_detect;
		logic settled;
		logic out_free;
	} rad_sts_t;

endpackage

FILE: rtl/resource_allocator_deadlock_detect.sv
// ----------------------------------------------------------------------------
// resource_allocator_deadlock_detect
// Single-instance resource allocator with iterative deadlock detection.
// ----------------------------------------------------------------------------
// Use:
//   req channel (req_valid/req_ready/req) carries one request: action,
//   process_index, resource_index. rsp channel (rsp_valid/rsp_ready/rsp)
//   returns exactly one status/victim_process result per request, in order.
//   APB port holds resources_in_use (byte address 0); write it while idle.
// Sequence (accept to rsp_valid):
//   release or invalid index: DECODE, FINISH, output register.
//   request: DECODE, DETECT (0..NUM_PROCESSES productive detection
//   rounds), FINISH, output register; each round checks every process at
//   once against the work vector, so the detection loop sets the request cost.
// Flow: one request in work at a time; a new one is taken only once the
//   sequencer is back in IDLE after the previous result is written.
// Reset: every resource free, held and pending matrices clear,
//   resources_in_use = 5; no clearing pass.
// Stall: the result sits in the output register while rsp_ready is low; the
//   next request is still accepted and worked on, and waits to be written
//   until the output register frees up.
// ----------------------------------------------------------------------------
module resource_allocator_deadlock_detect #(
	parameter int NUM_PROCESSES = rad_pkg::NUM_PROCESSES_DEF,
	parameter int NUM_RESOURCES = rad_pkg::NUM_RESOURCES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  rad_pkg::in_req_t            req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output rad_pkg::out_rsp_t           rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rad_pkg::PADDR_W-1:0] paddr,
	input  logic [rad_pkg::PDATA_W-1:0] pwdata,
	output logic [rad_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);

	rad_pkg::rad_cmd_t         cmd;
	rad_pkg::rad_sts_t         sts;
	logic [rad_pkg::CFG_W-1:0] cfg_count;

	// configuration register
	rad_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.cfg_count (cfg_count)
	);

	// sequencer
	rad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// matrices, detection rounds, output register
	rad_dpath #(
		.NUM_PROCESSES (NUM_PROCESSES),
		.NUM_RESOURCES (NUM_RESOURCES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.cfg_count (cfg_count),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

FILE: rtl/rad_cfg.sv
// ----------------------------------------------------------------------------
// rad_cfg
// APB register file: resources_in_use.
// ----------------------------------------------------------------------------
module rad_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rad_pkg::PADDR_W-1:0] paddr,
	input  logic [rad_pkg::PDATA_W-1:0] pwdata,
	output logic [rad_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output logic [rad_pkg::CFG_W-1:0]   cfg_count
);

	logic [rad_pkg::CFG_W-1:0] count_q;
	logic                      hit;

	assign hit    = (paddr[2] == rad_pkg::REG_RESOURCES_IN_USE);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= rad_pkg::RESOURCES_RESET;
		end else if (psel && penable && pwrite && hit) begin
			count_q <= pwdata[rad_pkg::CFG_W-1:0];
		end
	end

	assign prdata    = hit ? rad_pkg::PDATA_W'(count_q) : '0;
	assign cfg_count = count_q;

endmodule

FILE: rtl/rad_ctrl.sv
// ----------------------------------------------------------------------------
// rad_ctrl
// Sequencer: capture, decode, detection rounds, result write.
// ----------------------------------------------------------------------------
module rad_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  rad_pkg::rad_sts_t sts,
	output rad_pkg::rad_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_DECODE = 4'b0010,
		S_DETECT = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		req_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
				if (req_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.go_detect) begin
					cmd.start = 1'b1;
					state_d   = S_DETECT;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_DETECT: begin
				cmd.step = 1'b1;
				if (sts.settled) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/rad_dpath.sv
// ----------------------------------------------------------------------------
// rad_dpath
// Free vector, held/pending matrices, detection rounds, result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rad_dpath #(
	parameter int NUM_PROCESSES = rad_pkg::NUM_PROCESSES_DEF,
	parameter int NUM_RESOURCES = rad_pkg::NUM_RESOURCES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rad_pkg::rad_cmd_t         cmd,
	output rad_pkg::rad_sts_t         sts,
	input  rad_pkg::in_req_t          req,
	input  logic [rad_pkg::CFG_W-1:0] cfg_count,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output rad_pkg::out_rsp_t         rsp
);

	localparam int PW = $clog2(NUM_PROCESSES);
	localparam int IW = 7;  // holds 64

	typedef logic [NUM_RESOURCES-1:0] row_t;

	row_t                     free_q;
	row_t                     held_q [NUM_PROCESSES];
	row_t                     pend_q [NUM_PROCESSES];
	logic [NUM_PROCESSES-1:0] done_q;
	row_t                     work_q;
	rad_pkg::in_req_t         item_q;
	logic                     out_valid_q;
	rad_pkg::out_rsp_t        out_q;

	logic [IW-1:0]            proc_w, res_w, cnt;
	logic [PW-1:0]            proc_idx;
	row_t                     mask, res_bit, row_held, row_pend, gained, held_any;
	logic [NUM_PROCESSES-1:0] ok;
	logic                     item_ok, deadlock, out_free;
	logic [rad_pkg::STATUS_W-1:0] status_d;

	assign proc_w   = IW'(item_q.process_index);
	assign res_w    = IW'(item_q.resource_index);
	assign proc_idx = proc_w[PW-1:0];
	assign cnt      = (IW'(cfg_count) > IW'(NUM_RESOURCES)) ? IW'(NUM_RESOURCES)
	                                                         : IW'(cfg_count);

	always_comb begin
		for (int r = 0; r < NUM_RESOURCES; r++) begin
			mask[r]    = (IW'(r) < cnt);
			res_bit[r] = (res_w == IW'(r));
		end
	end

	assign item_ok  = (proc_w < IW'(NUM_PROCESSES)) && (res_w < cnt);
	assign row_held = held_q[proc_idx];
	assign row_pend = pend_q[proc_idx];

	// one detection round: every unfinished process whose requests lie in work
	always_comb begin
		gained   = '0;
		held_any = '0;
		for (int p = 0; p < NUM_PROCESSES; p++) begin
			ok[p] = !done_q[p] && ((pend_q[p] & mask & ~work_q) == '0);
			if (ok[p]) begin
				gained = gained | (held_q[p] & mask);
			end
			held_any = held_any | held_q[p];
		end
	end

	assign deadlock = ~&done_q;
	assign out_free = !out_valid_q || rsp_ready;

	always_comb begin
		if (!item_ok) begin
			status_d = rad_pkg::ST_INVALID;
		end else if (item_q.action == rad_pkg::ACT_RELEASE) begin
			status_d = rad_pkg::ST_RELEASED;
		end else if (deadlock) begin
			status_d = rad_pkg::ST_DEADLOCK;
		end else if (|(free_q & res_bit)) begin
			status_d = rad_pkg::ST_ALLOCATED;
		end else begin
			status_d = rad_pkg::ST_WAIT;
		end
	end

	assign sts.go_detect = item_ok && (item_q.action == rad_pkg::ACT_REQUEST);
	assign sts.settled   = ~|ok;
	assign sts.out_free  = out_free;

	// allocation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '1;
			for (int p = 0; p < NUM_PROCESSES; p++) begin
				held_q[p] <= '0;
				pend_q[p] <= '0;
			end
		end else if (cmd.start) begin
			pend_q[proc_idx] <= row_pend | res_bit;
		end else if (cmd.finish && item_ok) begin
			case (status_d)
				rad_pkg::ST_RELEASED: begin
					if (|(row_held & res_bit)) begin
						held_q[proc_idx] <= row_held & ~res_bit;
						free_q           <= free_q | res_bit;
					end else begin
						pend_q[proc_idx] <= row_pend & ~res_bit;
					end
				end
				rad_pkg::ST_DEADLOCK: begin
					free_q           <= free_q | (row_held & mask);
					held_q[proc_idx] <= row_held & ~mask;
					pend_q[proc_idx] <= row_pend & ~mask;
				end
				rad_pkg::ST_ALLOCATED: begin
					free_q           <= free_q & ~res_bit;
					held_q[proc_idx] <= row_held | res_bit;
					pend_q[proc_idx] <= row_pend & ~res_bit;
				end
				default: begin
					free_q <= free_q;
				end
			endcase
		end
	end

	// item, detection scratch and result payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= req;
		end
		if (cmd.start) begin
			work_q <= free_q & mask;
			for (int p = 0; p < NUM_PROCESSES; p++) begin
				done_q[p] <= ((held_q[p] & mask) == '0);
			end
		end else if (cmd.step) begin
			work_q <= work_q | gained;
			done_q <= done_q | ok;
		end
		if (cmd.finish) begin
			out_q.status         <= status_d;
			out_q.victim_process <= item_q.process_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	`RAD_NEVER(a_free_and_held, |(held_any & free_q), "resource both free and held")
	`RAD_ASSERT(a_finish_room, cmd.finish |-> out_free, "result written over pending one")
	`RAD_ASSERT(a_done_monotone, cmd.step |=> ((done_q & $past(done_q)) == $past(done_q)), "detection lost a finished process")

endmodule
